[rtl/cts_pkg.sv]
// Shared types and codes for the call trace statistics block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

  localparam logic [1:0] ST_BEGIN = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  localparam int QDEPTH = 4;
  localparam int TBL_W  = 160;

  typedef struct packed {
    logic        kind;
    logic [63:0] ticks;
    logic [7:0]  func_index;
    logic        new_session;
  } cts_event_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] call_ticks;
    logic [19:0] begin_position;
    logic [7:0]  func_out;
    logic [63:0] func_max_ticks;
    logic [63:0] func_total_ticks;
    logic [31:0] func_calls;
    logic [63:0] session_start;
    logic [63:0] session_end;
    logic [6:0]  deepest_nesting;
  } cts_result_t;

  // item handed from the front to the back
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] call_ticks;
    logic [19:0] begin_position;
    logic [7:0]  func_out;
    logic [63:0] session_start;
    logic [63:0] session_end;
    logic [6:0]  deepest_nesting;
  } cts_mid_t;

endpackage
`default_nettype wire

[rtl/cts_ram.sv]
// Generic single write port RAM with registered, enabled read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/cts_queue.sv]
// Short queue of classified items between the front and back parts.
// Depends on cts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cts_queue import cts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire cts_mid_t din,
  input  wire logic     pop,
  output logic          empty,
  output cts_mid_t      dout
);
  localparam int PW = $clog2(QDEPTH);

  cts_mid_t        slots [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (PW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

[rtl/cts_front.sv]
// Front part: accepts events, keeps session state and the nesting stack,
// classifies each event. Depends on cts_pkg and cts_ram.
`timescale 1ns / 1ps
`default_nettype none
module cts_front import cts_pkg::*; #(
  parameter int STACK_DEPTH   = 64,
  parameter int POSITION_BITS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       hold,
  input  wire logic       push,
  output logic            full,
  input  wire cts_event_t evt,
  output logic            q_push,
  input  wire logic       q_full,
  output cts_mid_t        q_item
);
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW     = $clog2(STACK_DEPTH);
  localparam int PB     = POSITION_BITS;
  localparam int SW     = 64 + 8 + PB;

  logic [FILL_W-1:0] fill, fill_eff, depth_rec, dep_eff;
  logic [PB-1:0]     counter, cnt_eff;
  logic [63:0]       least, greatest, least_eff, great_eff, least_new, great_new;
  logic              accept;

  logic              p1_valid;
  logic [1:0]        p1_status;
  logic [63:0]       p1_ticks;
  logic [PB-1:0]     p1_pos;
  logic [7:0]        p1_func;
  logic [63:0]       p1_min, p1_max;
  logic [FILL_W-1:0] p1_depth;
  logic [1:0]        status;

  logic              st_we, st_re;
  logic [AW-1:0]     st_waddr, st_raddr;
  logic [SW-1:0]     st_wdata, st_rdata;

  logic [63:0]       top_stamp;
  logic [7:0]        top_func;
  logic [PB-1:0]     top_pos;
  logic [PB+19:0]    pos_ext;
  logic [FILL_W+6:0] dep_ext;

  assign full   = hold || (p1_valid && q_full);
  assign accept = push && !full;

  // a new session clears before the event is handled
  always_comb begin
    fill_eff  = evt.new_session ? '0 : fill;
    cnt_eff   = evt.new_session ? '0 : counter;
    least_eff = evt.new_session ? '1 : least;
    great_eff = evt.new_session ? '0 : greatest;
    dep_eff   = evt.new_session ? '0 : depth_rec;
    least_new = (evt.ticks < least_eff) ? evt.ticks : least_eff;
    great_new = (evt.ticks > great_eff) ? evt.ticks : great_eff;
    if (!evt.kind) begin
      status = (fill_eff == FILL_W'(STACK_DEPTH)) ? ST_OVER : ST_BEGIN;
    end else begin
      status = (fill_eff == '0) ? ST_UNDER : ST_END;
    end
  end

  assign st_we    = accept && (status == ST_BEGIN);
  assign st_waddr = fill_eff[AW-1:0];
  assign st_wdata = {evt.ticks, evt.func_index, cnt_eff};
  assign st_re    = accept && (status == ST_END);
  assign st_raddr = AW'(fill_eff - 1'b1);

  cts_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .re   (st_re),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_status <= status;
      p1_ticks  <= evt.ticks;
      p1_pos    <= cnt_eff;
      p1_func   <= evt.func_index;
      p1_min    <= least_new;
      p1_max    <= great_new;
    end
    if (rst) begin
      fill      <= '0;
      counter   <= '0;
      least     <= '1;
      greatest  <= '0;
      depth_rec <= '0;
      p1_valid  <= 1'b0;
      p1_depth  <= '0;
    end else begin
      if (accept) begin
        counter  <= cnt_eff + 1'b1;
        least    <= least_new;
        greatest <= great_new;
        case (status)
          ST_BEGIN: begin
            fill      <= fill_eff + 1'b1;
            depth_rec <= (fill_eff + 1'b1 > dep_eff) ? fill_eff + 1'b1 : dep_eff;
            p1_depth  <= (fill_eff + 1'b1 > dep_eff) ? fill_eff + 1'b1 : dep_eff;
          end
          ST_END: begin
            fill      <= fill_eff - 1'b1;
            depth_rec <= dep_eff;
            p1_depth  <= dep_eff;
          end
          default: begin
            fill      <= fill_eff;
            depth_rec <= dep_eff;
            p1_depth  <= dep_eff;
          end
        endcase
      end
      if (accept)      p1_valid <= 1'b1;
      else if (q_push) p1_valid <= 1'b0;
    end
  end

  // stack entry read at accept shows up now
  assign {top_stamp, top_func, top_pos} = st_rdata;
  assign q_push = p1_valid && !q_full;

  always_comb begin
    dep_ext = {7'd0, p1_depth};
    pos_ext = '0;
    q_item  = '0;
    q_item.status          = p1_status;
    q_item.session_start   = p1_min;
    q_item.session_end     = p1_max;
    q_item.deepest_nesting = dep_ext[6:0];
    case (p1_status)
      ST_BEGIN: begin
        pos_ext         = {20'd0, p1_pos};
        q_item.func_out = p1_func;
      end
      ST_END: begin
        pos_ext           = {20'd0, top_pos};
        q_item.func_out   = top_func;
        q_item.call_ticks = p1_ticks - top_stamp;
      end
      default: begin
        pos_ext = '0;
      end
    endcase
    q_item.begin_position = pos_ext[19:0];
  end
endmodule
`default_nettype wire

[rtl/cts_back.sv]
// Back part: per-function statistics table update and result register.
// Depends on cts_pkg and cts_ram.
`timescale 1ns / 1ps
`default_nettype none
module cts_back import cts_pkg::*; #(
  parameter int FUNC_COUNT = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  output logic          clearing,
  input  wire logic     q_empty,
  output logic          q_pop,
  input  wire cts_mid_t q_item,
  output logic          empty,
  input  wire logic     pop,
  output cts_result_t   res
);
  localparam int SLOT_W = $clog2(FUNC_COUNT);

  logic [SLOT_W-1:0] slot_lut [256];
  logic [SLOT_W-1:0] clr_addr;

  logic              b_valid, b_leave, b_ready, b_fwd;
  cts_mid_t          b_item;
  logic [SLOT_W-1:0] b_slot;

  logic [SLOT_W-1:0] fwd_slot;
  logic [TBL_W-1:0]  fwd_data;

  logic              t_we;
  logic [SLOT_W-1:0] t_waddr;
  logic [TBL_W-1:0]  t_wdata, t_rdata, cur;
  logic [TBL_W-1:0]  upd;
  logic [63:0]       cur_max, cur_tot, new_max;
  logic [31:0]       cur_cnt;

  logic              out_valid;
  cts_result_t       out_res;

  // function index folded onto the table size
  always_comb begin
    for (int i = 0; i < 256; i++) begin
      slot_lut[i] = SLOT_W'(i % FUNC_COUNT);
    end
  end

  assign b_leave = b_valid && (!out_valid || pop);
  assign b_ready = !b_valid || b_leave;
  assign q_pop   = b_ready && !q_empty && !clearing;

  // forward the write made as this item entered; later ones cannot exist
  assign cur = (b_fwd && fwd_slot == b_slot) ? fwd_data : t_rdata;
  assign {cur_max, cur_tot, cur_cnt} = cur;
  assign new_max = (b_item.call_ticks > cur_max) ? b_item.call_ticks : cur_max;
  assign upd = {new_max, cur_tot + b_item.call_ticks, cur_cnt + 1'b1};

  always_comb begin
    if (clearing) begin
      t_we    = 1'b1;
      t_waddr = clr_addr;
      t_wdata = '0;
    end else begin
      t_we    = b_leave && (b_item.status == ST_END);
      t_waddr = b_slot;
      t_wdata = upd;
    end
  end

  cts_ram #(.WIDTH(TBL_W), .DEPTH(FUNC_COUNT)) u_table (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .re   (q_pop),
    .raddr(slot_lut[q_item.func_out]),
    .rdata(t_rdata)
  );

  always_comb begin
    out_res = '0;
    out_res.status          = b_item.status;
    out_res.call_ticks      = b_item.call_ticks;
    out_res.begin_position  = b_item.begin_position;
    out_res.func_out        = b_item.func_out;
    out_res.session_start   = b_item.session_start;
    out_res.session_end     = b_item.session_end;
    out_res.deepest_nesting = b_item.deepest_nesting;
    case (b_item.status)
      ST_BEGIN: begin
        {out_res.func_max_ticks, out_res.func_total_ticks, out_res.func_calls} = cur;
      end
      ST_END: begin
        {out_res.func_max_ticks, out_res.func_total_ticks, out_res.func_calls} = upd;
      end
      default: begin
        out_res.func_calls = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item <= q_item;
      b_slot <= slot_lut[q_item.func_out];
      b_fwd  <= b_leave && (b_item.status == ST_END);
    end
    if (b_leave && b_item.status == ST_END) begin
      fwd_slot <= b_slot;
      fwd_data <= upd;
    end
    if (b_leave) begin
      res <= out_res;
    end
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == SLOT_W'(FUNC_COUNT - 1)) clearing <= 1'b0;
        clr_addr <= clr_addr + 1'b1;
      end
      if (q_pop)        b_valid <= 1'b1;
      else if (b_leave) b_valid <= 1'b0;
      if (b_leave)      out_valid <= 1'b1;
      else if (pop)     out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;
endmodule
`default_nettype wire

[rtl/call_trace_stats.sv]
// Path: an accepted event passes through the front register, a queue slot, the
// back register and the result register. Throughput: one event per cycle
// while full stays low; the stack and the function table each have one write
// and one read port, with one-deep forwarding on the table. Reset:
// synchronous; afterwards the function table is zeroed while full stays high.
// Top level; depends on cts_pkg, cts_front, cts_queue, cts_back.
`timescale 1ns / 1ps
`default_nettype none
module call_trace_stats import cts_pkg::*; #(
  parameter int FUNC_COUNT    = 256,
  parameter int STACK_DEPTH   = 64,
  parameter int POSITION_BITS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire cts_event_t evt,
  output logic            empty,
  input  wire logic       pop,
  output cts_result_t     res
);
  logic     clearing;
  logic     mq_push, mq_full, mq_pop, mq_empty;
  cts_mid_t mq_in, mq_out;

  cts_front #(.STACK_DEPTH(STACK_DEPTH), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk   (clk),
    .rst   (rst),
    .hold  (clearing),
    .push  (push),
    .full  (full),
    .evt   (evt),
    .q_push(mq_push),
    .q_full(mq_full),
    .q_item(mq_in)
  );

  cts_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (mq_push),
    .full (mq_full),
    .din  (mq_in),
    .pop  (mq_pop),
    .empty(mq_empty),
    .dout (mq_out)
  );

  cts_back #(.FUNC_COUNT(FUNC_COUNT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .clearing(clearing),
    .q_empty (mq_empty),
    .q_pop   (mq_pop),
    .q_item  (mq_out),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );
endmodule
`default_nettype wire

[rtl/cts_checker.sv]
// Port-level checks for call_trace_stats, bound to the top level.
// Depends on cts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cts_checker import cts_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire cts_result_t res
);
  // table is being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> full)
    else $error("full low right after reset");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (res.status == ST_UNDER || res.status == ST_OVER)) |->
      (res.call_ticks == '0 && res.func_calls == '0 && res.func_out == '0))
    else $error("flagged item carries statistics");

  a_begin_no_length: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.status == ST_BEGIN) |-> res.call_ticks == '0)
    else $error("begin item with call length");

  a_session_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> res.session_start <= res.session_end)
    else $error("session start after session end");
endmodule

bind call_trace_stats cts_checker u_chk (.*);
`default_nettype wire

[tb/tb_call_trace_stats.sv]
// Testbench for call_trace_stats: drives profiler begin/end events through the
// queue-style ports and checks each result against an in-bench predictor.
// Depends on cts_pkg and the call_trace_stats RTL.
`timescale 1ns / 1ps
module tb_call_trace_stats;
  import cts_pkg::*;

  localparam int NFUNC = 256;
  localparam int NSTACK = 64;
  localparam int WATCH_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  cts_event_t evt = '0;
  cts_result_t res;

  call_trace_stats uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .evt(evt),
    .empty(empty), .pop(pop), .res(res)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [63:0] stk_stamp [NSTACK];
  logic [7:0]  stk_func [NSTACK];
  logic [19:0] stk_pos [NSTACK];
  int unsigned fill;
  logic [19:0] evt_pos;
  logic [63:0] lo_stamp, hi_stamp;
  int unsigned depth_hi;
  logic [63:0] fmax_tbl [NFUNC];
  logic [63:0] fsum_tbl [NFUNC];
  logic [31:0] fcnt_tbl [NFUNC];

  cts_result_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_end = 0, n_under = 0, n_over = 0;
  int idle_pct = 16;
  int watch = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("mismatch item %0d %s: got %h exp %h", n_got, what, got, exp);
  endtask

  function automatic cts_result_t predict_event(input cts_event_t e);
    cts_result_t r;
    logic [19:0] p;
    int unsigned t;
    r = '0;
    if (e.new_session) begin
      fill = 0; evt_pos = 0; lo_stamp = '1; hi_stamp = 0; depth_hi = 0;
    end
    p = evt_pos;
    evt_pos = evt_pos + 20'd1;
    if (e.ticks < lo_stamp) lo_stamp = e.ticks;
    if (e.ticks > hi_stamp) hi_stamp = e.ticks;
    if (e.kind == 1'b0) begin
      if (fill >= NSTACK) begin
        r.status = ST_OVER;
      end else begin
        stk_stamp[fill] = e.ticks;
        stk_func[fill] = e.func_index;
        stk_pos[fill] = p;
        fill++;
        if (fill > depth_hi) depth_hi = fill;
        r.status = ST_BEGIN;
        r.begin_position = p;
        r.func_out = e.func_index;
        r.func_max_ticks = fmax_tbl[e.func_index];
        r.func_total_ticks = fsum_tbl[e.func_index];
        r.func_calls = fcnt_tbl[e.func_index];
      end
    end else begin
      if (fill == 0) begin
        r.status = ST_UNDER;
      end else begin
        t = fill - 1;
        fill = t;
        r.call_ticks = e.ticks - stk_stamp[t];
        if (r.call_ticks > fmax_tbl[stk_func[t]]) fmax_tbl[stk_func[t]] = r.call_ticks;
        fsum_tbl[stk_func[t]] += r.call_ticks;
        fcnt_tbl[stk_func[t]] += 1;
        r.status = ST_END;
        r.begin_position = stk_pos[t];
        r.func_out = stk_func[t];
        r.func_max_ticks = fmax_tbl[stk_func[t]];
        r.func_total_ticks = fsum_tbl[stk_func[t]];
        r.func_calls = fcnt_tbl[stk_func[t]];
      end
    end
    r.session_start = lo_stamp;
    r.session_end = hi_stamp;
    r.deepest_nesting = depth_hi[6:0];
    return r;
  endfunction

  // one item: random gap, then hold push until accepted
  task automatic send_event(input cts_event_t e);
    while ($urandom_range(99) < idle_pct) begin
      push <= 0;
      @(negedge clk);
    end
    evt <= e;
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_results.push_back(predict_event(e));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic cts_event_t mk(input logic k, input logic [63:0] t,
                                    input logic [7:0] f, input logic s);
    cts_event_t e;
    e.kind = k; e.ticks = t; e.func_index = f; e.new_session = s;
    return e;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result side: random pop at falling edge, check at rising edge
  always @(negedge clk) pop <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    cts_result_t x;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 64'(res.status), 64'd0);
      end else begin
        x = expected_results.pop_front();
        if (res.status != x.status) report("status", res.status, x.status);
        if (res.call_ticks != x.call_ticks) report("call_ticks", res.call_ticks, x.call_ticks);
        if (res.begin_position != x.begin_position)
          report("begin_position", res.begin_position, x.begin_position);
        if (res.func_out != x.func_out) report("func_out", res.func_out, x.func_out);
        if (res.func_max_ticks != x.func_max_ticks)
          report("func_max_ticks", res.func_max_ticks, x.func_max_ticks);
        if (res.func_total_ticks != x.func_total_ticks)
          report("func_total_ticks", res.func_total_ticks, x.func_total_ticks);
        if (res.func_calls != x.func_calls) report("func_calls", res.func_calls, x.func_calls);
        if (res.session_start != x.session_start)
          report("session_start", res.session_start, x.session_start);
        if (res.session_end != x.session_end)
          report("session_end", res.session_end, x.session_end);
        if (res.deepest_nesting != x.deepest_nesting)
          report("deepest_nesting", res.deepest_nesting, x.deepest_nesting);
        case (x.status)
          ST_END: n_end++;
          ST_UNDER: n_under++;
          ST_OVER: n_over++;
          default: ;
        endcase
      end
      n_got++;
    end
  end

  // watchdog: cycles with nothing accepted; reset clearing pass is far below limit
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WATCH_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_extremes();
    send_event(mk(1'b1, 64'd5, 8'd0, 1'b1));            // underflow on empty stack
    send_event(mk(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0));
    send_event(mk(1'b1, 64'd3, 8'd0, 1'b0));            // wrapping length
    send_event(mk(1'b0, 64'd0, 8'd0, 1'b0));
    send_event(mk(1'b0, 64'd100, 8'hAA, 1'b0));
    send_event(mk(1'b1, 64'd250, 8'h55, 1'b0));
    send_event(mk(1'b1, 64'd400, 8'h00, 1'b0));
    send_event(mk(1'b1, 64'd1, 8'h00, 1'b0));           // underflow again
    send_event(mk(1'b0, 64'd7, 8'hFF, 1'b1));           // new session, tables kept
    send_event(mk(1'b1, 64'd9, 8'h00, 1'b0));
  endtask

  task automatic test_overflow();
    for (int i = 0; i < NSTACK + 3; i++)
      send_event(mk(1'b0, 64'(1000 + i), 8'(i), i == 0));
    for (int i = 0; i < NSTACK + 2; i++)
      send_event(mk(1'b1, 64'(5000 + i), 8'd0, 1'b0));
  endtask

  task automatic drain();
    push <= 0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_random(input int n);
    int d;
    cts_event_t e;
    d = 0;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) idle_pct = 0;          // stretch with no idling
      if (i == n / 2) idle_pct = 16;
      if (i == (2 * n) / 3) drain();         // sender holds until all results are back
      e.new_session = ($urandom_range(99) < 3);
      if (e.new_session) d = 0;
      // mostly balanced nesting; some deep dives and strays
      if (d == 0) e.kind = ($urandom_range(9) == 0);
      else if (d > 60) e.kind = ($urandom_range(3) != 0);
      else e.kind = $urandom_range(1);
      e.func_index = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
      e.ticks = ($urandom_range(3) == 0) ? rand64() : 64'(i * 50 + $urandom_range(40));
      if (e.kind == 1'b0) begin
        if (d < NSTACK) d++;
      end else if (d > 0) d--;
      send_event(e);
    end
  endtask

  initial begin
    fill = 0; evt_pos = 0; lo_stamp = '1; hi_stamp = 0; depth_hi = 0;
    for (int i = 0; i < NFUNC; i++) begin
      fmax_tbl[i] = 0; fsum_tbl[i] = 0; fcnt_tbl[i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_extremes();
    test_overflow();
    test_random(560);
    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d events, checked %0d results", n_sent, n_got);
    $display("ends %0d, underflows %0d, overflows %0d", n_end, n_under, n_over);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
